// ===== design/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants of the S-expression tree builder
// Result beat layout, event and error codes, stack request and byte classes.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int STB_NODE_CAPACITY = 1024;
  localparam int STB_MAX_DEPTH     = 64;
  localparam int STB_POS_BITS      = 16;

  localparam int NODE_OUT_W  = 10;
  localparam int POS_OUT_W   = 16;
  localparam int DEPTH_OUT_W = 7;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef logic [NODE_OUT_W-1:0]  node_out_t;
  typedef logic [POS_OUT_W-1:0]   pos_out_t;
  typedef logic [DEPTH_OUT_W-1:0] depth_out_t;

  typedef enum logic [2:0] {
    EV_WORD   = 3'd0,
    EV_OPEN   = 3'd1,
    EV_CLOSE  = 3'd2,
    EV_FINISH = 3'd3,
    EV_ERROR  = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNMATCHED  = 2'd1,
    ERR_TOO_DEEP   = 2'd2,
    ERR_STORE_FULL = 2'd3
  } err_t;

  typedef struct packed {
    ev_t        ev;
    node_out_t  node;
    node_out_t  parent;
    node_out_t  link_from;
    logic       link_is_child;
    pos_out_t   span_start;
    pos_out_t   span_end;
    depth_out_t open_depth;
    err_t       err;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    STK_HOLD  = 2'd0,
    STK_PUSH  = 2'd1,
    STK_POP   = 2'd2,
    STK_CLEAR = 2'd3
  } stk_op_t;

  typedef struct packed {
    stk_op_t op;
    logic    set_last;
  } stb_stk_req_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) ||
           (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
  endfunction

endpackage

// ===== design/stb_ram.sv =====
// ----------------------------------------------------------------------------
// stb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module stb_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== design/stb_stack.sv =====
// ----------------------------------------------------------------------------
// stb_stack: group stack with cached top and next-below entries
// Each entry holds a group node and its last child. The top two entries live
// in registers; deeper entries live in the RAM, and the entry third from the
// top is read every cycle so that a pop can refill the cache at once.
// ----------------------------------------------------------------------------
module stb_stack import stb_pkg::*; #(
  parameter int NODE_W    = 10,
  parameter int MAX_DEPTH = STB_MAX_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stb_stk_req_t                   req,
  input  logic [NODE_W-1:0]              last_val,
  input  logic [NODE_W-1:0]              grp_node,
  output logic [NODE_W-1:0]              top_parent,
  output logic [NODE_W-1:0]              top_last,
  output logic [NODE_W-1:0]              below_parent,
  output logic [$clog2(MAX_DEPTH+1)-1:0] top_cnt
);

  localparam int TOP_W  = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W = $clog2(MAX_DEPTH);
  localparam int ENT_W  = 2 * NODE_W;

  logic [TOP_W-1:0]  top_cnt_r, top_cnt_nxt;
  logic [NODE_W-1:0] tp_r, tp_nxt;
  logic [NODE_W-1:0] tl_r, tl_nxt;
  logic [ENT_W-1:0]  below_r, below_nxt;
  logic              fwd_valid_r, fwd_valid_nxt;
  logic [ENT_W-1:0]  fwd_data_r;

  logic [TOP_W-1:0]  top_m2, top_m3;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [ENT_W-1:0]  rdata, third;

  assign third = fwd_valid_r ? fwd_data_r : rdata;

  always_comb begin
    top_cnt_nxt = top_cnt_r;
    tp_nxt      = tp_r;
    tl_nxt      = tl_r;
    below_nxt   = below_r;
    we          = 1'b0;
    top_m2      = top_cnt_r - TOP_W'(2);
    waddr       = top_m2[ADDR_W-1:0];
    case (req.op)
      STK_HOLD: begin
        if (req.set_last) begin
          tl_nxt = last_val;
        end
      end
      STK_PUSH: begin
        // spill the old next-below entry into the RAM
        we          = (top_cnt_r >= TOP_W'(2));
        below_nxt   = {tp_r, grp_node};
        tp_nxt      = grp_node;
        tl_nxt      = grp_node;
        top_cnt_nxt = top_cnt_r + TOP_W'(1);
      end
      STK_POP: begin
        tp_nxt      = below_r[ENT_W-1:NODE_W];
        tl_nxt      = below_r[NODE_W-1:0];
        below_nxt   = third;
        top_cnt_nxt = top_cnt_r - TOP_W'(1);
      end
      STK_CLEAR: begin
        tp_nxt      = '0;
        tl_nxt      = '0;
        top_cnt_nxt = TOP_W'(1);
      end
      default: begin
        top_cnt_nxt = top_cnt_r;
      end
    endcase
    top_m3        = top_cnt_nxt - TOP_W'(3);
    raddr         = (top_cnt_nxt < TOP_W'(3)) ? '0 : top_m3[ADDR_W-1:0];
    fwd_valid_nxt = we && (waddr == raddr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_cnt_r   <= TOP_W'(1);
      tp_r        <= '0;
      tl_r        <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      top_cnt_r   <= top_cnt_nxt;
      tp_r        <= tp_nxt;
      tl_r        <= tl_nxt;
      fwd_valid_r <= fwd_valid_nxt;
    end
    below_r    <= below_nxt;
    fwd_data_r <= below_r;
  end

  stb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (below_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign top_parent   = tp_r;
  assign top_last     = tl_r;
  assign below_parent = below_r[ENT_W-1:NODE_W];
  assign top_cnt      = top_cnt_r;

endmodule

// ===== design/stb_res_fifo.sv =====
// ----------------------------------------------------------------------------
// stb_res_fifo: four-deep result queue
// Takes up to two result beats per cycle, in order, and hands out one.
// ----------------------------------------------------------------------------
module stb_res_fifo import stb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_a,
  input  res_t res_a,
  input  logic push_b,
  input  res_t res_b,
  output logic room,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  res_t               ent_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic [FIFO_AW-1:0] wr_p1;
  logic               pop;
  logic [1:0]         n_push;

  assign wr_p1     = wr_r + FIFO_AW'(1);
  assign pop       = out_valid && out_ready;
  assign n_push    = {1'b0, push_a} + {1'b0, push_b};
  assign out_valid = (cnt_r != '0);
  assign out_res   = ent_r[rd_r];
  // room for the worst case of two beats
  assign room      = (cnt_r <= FIFO_CW'(FIFO_DEPTH - 2));

  always_comb begin
    wr_nxt  = wr_r + FIFO_AW'(n_push);
    rd_nxt  = pop ? rd_r + FIFO_AW'(1) : rd_r;
    cnt_nxt = cnt_r + FIFO_CW'(n_push) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push_a) begin
      ent_r[wr_r] <= res_a;
      if (push_b) begin
        ent_r[wr_p1] <= res_b;
      end
    end else if (push_b) begin
      ent_r[wr_r] <= res_b;
    end
  end

endmodule

// ===== design/sexpr_tree_builder.sv =====
// ----------------------------------------------------------------------------
// sexpr_tree_builder: incremental S-expression tree builder
// Parses text one byte per beat and reports every word and group node with
// its parent and the earlier link that now points to it, plus group closes,
// errors and the finish of each text.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  in_      | input     | in_valid/in_ready  | req_type, byte_value
//  out_     | output    | out_valid/out_ready| event_res .. error_code, last
//
//  One input beat per cycle is taken while the result queue has room for two
//  beats; each byte takes the single read-modify-write of the cached stack
//  top. A byte gives zero, one or two result beats; with an empty queue the
//  first of them appears at out_ in the cycle after the input beat is taken.
//  Output drains at one beat per cycle; a stalled out_ready lets beats gather
//  in the four-deep queue, and in_ready drops while more than two are held.
//  Reset is synchronous, active low, and needs no clearing pass: the stack
//  RAM is only read where written.
//
module sexpr_tree_builder import stb_pkg::*; #(
  parameter int NODE_CAPACITY = STB_NODE_CAPACITY,
  parameter int MAX_DEPTH     = STB_MAX_DEPTH,
  parameter int POS_BITS      = STB_POS_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_res,
  output logic [9:0] out_node_index,
  output logic [9:0] out_parent_index,
  output logic [9:0] out_link_from,
  output logic       out_link_is_child,
  output logic [15:0] out_span_start,
  output logic [15:0] out_span_end,
  output logic [6:0] out_open_depth,
  output logic [1:0] out_error_code,
  output logic       out_last
);

  localparam int NODE_W = $clog2(NODE_CAPACITY);
  localparam int CNT_W  = $clog2(NODE_CAPACITY + 1);
  localparam int TOP_W  = $clog2(MAX_DEPTH + 1);

  // scalar parse state
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic                in_word_r, in_word_nxt;
  logic [POS_BITS-1:0] word_start_r, word_start_nxt;
  logic [CNT_W-1:0]    node_cnt_r, node_cnt_nxt;

  // stack view
  stb_stk_req_t        stk_req;
  logic [NODE_W-1:0]   top_parent, top_last, below_parent;
  logic [TOP_W-1:0]    top_cnt;

  logic                accept;
  logic                is_end, is_open, is_close, delim;
  logic                word_fire, word_ok, word_made, store_ok;
  logic                too_deep, open_made, close_ok;
  logic [CNT_W-1:0]    cnt1;
  logic [NODE_W-1:0]   last1;
  logic                res_a_vld, res_b_vld;
  res_t                res_a, res_b, out_res;

  assign accept   = in_valid && in_ready;
  assign is_end   = in_req_type;
  assign is_open  = !is_end && (in_byte_value == CH_OPEN);
  assign is_close = !is_end && (in_byte_value == CH_CLOSE);
  assign delim    = is_end || is_open || is_close || is_blank(in_byte_value);

  // a pending word ends at any delimiter and becomes the first beat
  assign word_fire = in_word_r && delim;
  assign word_ok   = (node_cnt_r < CNT_W'(NODE_CAPACITY));
  assign word_made = word_fire && word_ok;
  assign cnt1      = word_made ? node_cnt_r + CNT_W'(1) : node_cnt_r;
  assign last1     = word_made ? NODE_W'(node_cnt_r) : top_last;

  assign too_deep  = (top_cnt >= TOP_W'(MAX_DEPTH));
  assign store_ok  = (cnt1 < CNT_W'(NODE_CAPACITY));
  assign open_made = is_open && !too_deep && store_ok;
  assign close_ok  = is_close && (top_cnt > TOP_W'(1));

  assign res_a_vld = word_fire;
  assign res_b_vld = is_end || is_open || is_close;

  // first beat: the word node, or store full
  always_comb begin
    res_a            = '0;
    res_a.parent     = node_out_t'(top_parent);
    res_a.open_depth = depth_out_t'(top_cnt - TOP_W'(1));
    res_a.last       = !res_b_vld;
    if (word_ok) begin
      res_a.ev            = EV_WORD;
      res_a.node          = node_out_t'(node_cnt_r);
      res_a.link_from     = node_out_t'(top_last);
      res_a.link_is_child = (top_last == top_parent);
      res_a.span_start    = pos_out_t'(word_start_r);
      res_a.span_end      = pos_out_t'(pos_r);
      res_a.err           = ERR_NONE;
    end else begin
      res_a.ev         = EV_ERROR;
      res_a.span_start = pos_out_t'(pos_r);
      res_a.span_end   = pos_out_t'(pos_r);
      res_a.err        = ERR_STORE_FULL;
    end
  end

  // second beat: finish, group open or close, or their errors
  always_comb begin
    res_b            = '0;
    res_b.parent     = node_out_t'(top_parent);
    res_b.open_depth = depth_out_t'(top_cnt - TOP_W'(1));
    res_b.last       = 1'b1;
    res_b.span_start = pos_out_t'(pos_r);
    res_b.span_end   = pos_out_t'(pos_r);
    res_b.ev         = EV_ERROR;
    res_b.err        = ERR_NONE;
    if (is_end) begin
      res_b.ev         = EV_FINISH;
      res_b.span_start = '0;
    end else if (is_open) begin
      if (too_deep) begin
        res_b.err = ERR_TOO_DEEP;
      end else if (!store_ok) begin
        res_b.err = ERR_STORE_FULL;
      end else begin
        res_b.ev            = EV_OPEN;
        res_b.node          = node_out_t'(cnt1);
        res_b.link_from     = node_out_t'(last1);
        res_b.link_is_child = (last1 == top_parent);
        res_b.span_end      = '0;
        res_b.open_depth    = depth_out_t'(top_cnt);
      end
    end else if (!close_ok) begin
      res_b.err = ERR_UNMATCHED;
    end else begin
      // close: report the popped group under its own parent
      res_b.ev         = EV_CLOSE;
      res_b.node       = node_out_t'(top_parent);
      res_b.parent     = node_out_t'(below_parent);
      res_b.span_start = '0;
      res_b.open_depth = depth_out_t'(top_cnt - TOP_W'(2));
    end
  end

  // stack request: one operation per accepted beat
  always_comb begin
    stk_req.op       = STK_HOLD;
    stk_req.set_last = 1'b0;
    if (accept) begin
      if (is_end) begin
        stk_req.op = STK_CLEAR;
      end else if (open_made) begin
        stk_req.op = STK_PUSH;
      end else if (close_ok) begin
        stk_req.op = STK_POP;
      end else begin
        stk_req.set_last = word_made;
      end
    end
  end

  // scalar state update; finish returns everything to the reset state
  always_comb begin
    pos_nxt        = pos_r;
    in_word_nxt    = in_word_r;
    word_start_nxt = word_start_r;
    node_cnt_nxt   = node_cnt_r;
    if (accept) begin
      if (is_end) begin
        pos_nxt        = '0;
        in_word_nxt    = 1'b0;
        word_start_nxt = '0;
        node_cnt_nxt   = CNT_W'(1);
      end else begin
        pos_nxt      = pos_r + POS_BITS'(1);
        node_cnt_nxt = open_made ? cnt1 + CNT_W'(1) : cnt1;
        if (delim) begin
          in_word_nxt = 1'b0;
        end else if (!in_word_r) begin
          in_word_nxt    = 1'b1;
          word_start_nxt = pos_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      in_word_r    <= 1'b0;
      word_start_r <= '0;
      node_cnt_r   <= CNT_W'(1);
    end else begin
      pos_r        <= pos_nxt;
      in_word_r    <= in_word_nxt;
      word_start_r <= word_start_nxt;
      node_cnt_r   <= node_cnt_nxt;
    end
  end

  stb_stack #(
    .NODE_W    (NODE_W),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (stk_req),
    .last_val     (NODE_W'(node_cnt_r)),
    .grp_node     (NODE_W'(cnt1)),
    .top_parent   (top_parent),
    .top_last     (top_last),
    .below_parent (below_parent),
    .top_cnt      (top_cnt)
  );

  stb_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (accept && res_a_vld),
    .res_a     (res_a),
    .push_b    (accept && res_b_vld),
    .res_b     (res_b),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_event_res     = out_res.ev;
  assign out_node_index    = out_res.node;
  assign out_parent_index  = out_res.parent;
  assign out_link_from     = out_res.link_from;
  assign out_link_is_child = out_res.link_is_child;
  assign out_span_start    = out_res.span_start;
  assign out_span_end      = out_res.span_end;
  assign out_open_depth    = out_res.open_depth;
  assign out_error_code    = out_res.err;
  assign out_last          = out_res.last;

endmodule
